/* rtl/xo256_pkg.sv */
// Package for the xoshiro256++ generator: operation codes, datapath commands,
// controller/datapath interface structs, mixing and jump constants.
// No dependencies.
package xo256_pkg;

  typedef enum logic [1:0] {
    OP_SEED      = 2'd0,
    OP_NEXT      = 2'd1,
    OP_JUMP      = 2'd2,
    OP_LONG_JUMP = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIX_A,
    ST_MUL_A,
    ST_MIX_B,
    ST_MUL_B,
    ST_STORE,
    ST_NEXT_SUM,
    ST_NEXT_STEP,
    ST_JUMP,
    ST_JUMP_END,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MIX,
    CMD_MUL,
    CMD_STORE,
    CMD_SUM,
    CMD_STEP,
    CMD_JSTEP,
    CMD_JEND,
    CMD_EMIT
  } dp_cmd_t;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned HALF_W  = WORD_W / 2;
  localparam int unsigned NWORDS  = 4;
  localparam int unsigned WIDX_W  = $clog2(NWORDS);
  localparam int unsigned JCNT_W  = $clog2(NWORDS * WORD_W);
  localparam int unsigned PHASE_W = 2;
  localparam logic [PHASE_W-1:0] MUL_LAST = 2'd2;

  typedef struct packed {
    dp_cmd_t             cmd;
    logic [WIDX_W-1:0]   word;
    logic [PHASE_W-1:0]  phase;
    logic                mul_b;
    logic                acc_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94d049bb133111eb;

  localparam logic [WORD_W-1:0] JUMP_POLY_0 = 64'h180ec6d33cfd0aba;
  localparam logic [WORD_W-1:0] JUMP_POLY_1 = 64'hd5a61266f0c9392c;
  localparam logic [WORD_W-1:0] JUMP_POLY_2 = 64'ha9582618e03fc9aa;
  localparam logic [WORD_W-1:0] JUMP_POLY_3 = 64'h39abdc4529b1661c;

  localparam logic [WORD_W-1:0] LJUMP_POLY_0 = 64'h76e15d3efefdcbbf;
  localparam logic [WORD_W-1:0] LJUMP_POLY_1 = 64'hc5004e441c522fb3;
  localparam logic [WORD_W-1:0] LJUMP_POLY_2 = 64'h77710069854ee241;
  localparam logic [WORD_W-1:0] LJUMP_POLY_3 = 64'h39109bb02acbe635;

  // Bit idx of the jump polynomial, word-major, LSB first.
  function automatic logic poly_bit(input logic is_long, input logic [JCNT_W-1:0] idx);
    logic [WORD_W-1:0] pw;
    pw = '0;
    unique case (idx[JCNT_W-1 -: WIDX_W])
      2'd0: pw = is_long ? LJUMP_POLY_0 : JUMP_POLY_0;
      2'd1: pw = is_long ? LJUMP_POLY_1 : JUMP_POLY_1;
      2'd2: pw = is_long ? LJUMP_POLY_2 : JUMP_POLY_2;
      2'd3: pw = is_long ? LJUMP_POLY_3 : JUMP_POLY_3;
      default: pw = '0;
    endcase
    return pw[idx[JCNT_W-WIDX_W-1:0]];
  endfunction

endpackage

/* rtl/xo256_ctrl.sv */
// Controller state machine for the xoshiro256++ generator.
// Sequences seed, next and jump operations; uses xo256_pkg.
module xo256_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            operation,
  input  xo256_pkg::dp_status_t status,
  output xo256_pkg::ctrl_cmd_t  cmd
);

  xo256_pkg::state_t                  state, state_next;
  xo256_pkg::op_t                     op, op_next;
  logic [xo256_pkg::WIDX_W-1:0]       word, word_next;
  logic [xo256_pkg::PHASE_W-1:0]      mphase, mphase_next;
  logic [xo256_pkg::JCNT_W-1:0]       jcount, jcount_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= xo256_pkg::ST_IDLE;
      op     <= xo256_pkg::OP_SEED;
      word   <= '0;
      mphase <= '0;
      jcount <= '0;
    end else begin
      state  <= state_next;
      op     <= op_next;
      word   <= word_next;
      mphase <= mphase_next;
      jcount <= jcount_next;
    end
  end

  always_comb begin
    state_next  = state;
    op_next     = op;
    word_next   = word;
    mphase_next = mphase;
    jcount_next = jcount;
    in_ready    = 1'b0;
    cmd.cmd     = xo256_pkg::CMD_NONE;
    cmd.word    = word;
    cmd.phase   = mphase;
    cmd.mul_b   = 1'b0;
    cmd.acc_en  = xo256_pkg::poly_bit(op == xo256_pkg::OP_LONG_JUMP, jcount);
    unique case (state)
      xo256_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cmd     = xo256_pkg::CMD_LOAD;
          op_next     = xo256_pkg::op_t'(operation);
          word_next   = '0;
          mphase_next = '0;
          jcount_next = '0;
          unique case (xo256_pkg::op_t'(operation))
            xo256_pkg::OP_SEED:      state_next = xo256_pkg::ST_MIX_A;
            xo256_pkg::OP_NEXT:      state_next = xo256_pkg::ST_NEXT_SUM;
            xo256_pkg::OP_JUMP:      state_next = xo256_pkg::ST_JUMP;
            xo256_pkg::OP_LONG_JUMP: state_next = xo256_pkg::ST_JUMP;
            default:                 state_next = xo256_pkg::ST_JUMP;
          endcase
        end
      end
      xo256_pkg::ST_MIX_A: begin
        cmd.cmd    = xo256_pkg::CMD_MIX;
        state_next = xo256_pkg::ST_MUL_A;
      end
      xo256_pkg::ST_MUL_A: begin
        cmd.cmd = xo256_pkg::CMD_MUL;
        if (mphase == xo256_pkg::MUL_LAST) begin
          mphase_next = '0;
          state_next  = xo256_pkg::ST_MIX_B;
        end else begin
          mphase_next = mphase + 1'b1;
        end
      end
      xo256_pkg::ST_MIX_B: begin
        cmd.cmd    = xo256_pkg::CMD_MIX;
        cmd.mul_b  = 1'b1;
        state_next = xo256_pkg::ST_MUL_B;
      end
      xo256_pkg::ST_MUL_B: begin
        cmd.cmd   = xo256_pkg::CMD_MUL;
        cmd.mul_b = 1'b1;
        if (mphase == xo256_pkg::MUL_LAST) begin
          mphase_next = '0;
          state_next  = xo256_pkg::ST_STORE;
        end else begin
          mphase_next = mphase + 1'b1;
        end
      end
      xo256_pkg::ST_STORE: begin
        cmd.cmd = xo256_pkg::CMD_STORE;
        if (word == xo256_pkg::WIDX_W'(xo256_pkg::NWORDS - 1)) begin
          state_next = xo256_pkg::ST_DONE;
        end else begin
          word_next  = word + 1'b1;
          state_next = xo256_pkg::ST_MIX_A;
        end
      end
      xo256_pkg::ST_NEXT_SUM: begin
        cmd.cmd    = xo256_pkg::CMD_SUM;
        state_next = xo256_pkg::ST_NEXT_STEP;
      end
      xo256_pkg::ST_NEXT_STEP: begin
        cmd.cmd    = xo256_pkg::CMD_STEP;
        state_next = xo256_pkg::ST_DONE;
      end
      xo256_pkg::ST_JUMP: begin
        cmd.cmd     = xo256_pkg::CMD_JSTEP;
        jcount_next = jcount + 1'b1;
        if (jcount == '1) begin
          state_next = xo256_pkg::ST_JUMP_END;
        end
      end
      xo256_pkg::ST_JUMP_END: begin
        cmd.cmd    = xo256_pkg::CMD_JEND;
        state_next = xo256_pkg::ST_DONE;
      end
      xo256_pkg::ST_DONE: begin
        // hold the result until the output register is free
        if (status.out_free) begin
          cmd.cmd    = xo256_pkg::CMD_EMIT;
          state_next = xo256_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = xo256_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/xo256_dp.sv */
// Datapath for the xoshiro256++ generator: state words, seed mixer with a
// shared 32x32 multiplier, jump accumulator and output register. Uses xo256_pkg.
module xo256_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  xo256_pkg::ctrl_cmd_t             cmd,
  output xo256_pkg::dp_status_t            status,
  input  logic [xo256_pkg::WORD_W-1:0]     seed_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [xo256_pkg::WORD_W-1:0]     random_value,
  output logic                             value_valid
);

  localparam int unsigned W = xo256_pkg::WORD_W;
  localparam int unsigned H = xo256_pkg::HALF_W;

  logic [W-1:0] gen_state [xo256_pkg::NWORDS];
  logic [W-1:0] acc       [xo256_pkg::NWORDS];
  logic [W-1:0] adv       [xo256_pkg::NWORDS];
  logic [W-1:0] z, mx, prod, sum, res_value;
  logic         res_flag;
  logic [W-1:0] mconst, t2, t3;
  logic [H-1:0] mul_a, mul_b;
  logic [W-1:0] mul_p;

  // One xoshiro256 state step.
  assign t2     = gen_state[2] ^ gen_state[0];
  assign t3     = gen_state[3] ^ gen_state[1];
  assign adv[0] = gen_state[0] ^ t3;
  assign adv[1] = gen_state[1] ^ t2;
  assign adv[2] = t2 ^ (gen_state[1] << 17);
  assign adv[3] = {t3[W-46:0], t3[W-1:W-45]};

  // 64x64 low product in three passes: lo*lo, hi*lo, lo*hi.
  assign mconst = cmd.mul_b ? xo256_pkg::MIX_MUL_B : xo256_pkg::MIX_MUL_A;
  assign mul_a  = (cmd.phase == 2'd1) ? mx[W-1:H] : mx[H-1:0];
  assign mul_b  = (cmd.phase == xo256_pkg::MUL_LAST) ? mconst[W-1:H] : mconst[H-1:0];
  assign mul_p  = W'(mul_a) * W'(mul_b);

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < xo256_pkg::NWORDS; i++) begin
        gen_state[i] <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      unique case (cmd.cmd)
        xo256_pkg::CMD_STORE: gen_state[cmd.word] <= prod ^ (prod >> 31);
        xo256_pkg::CMD_STEP: begin
          for (int i = 0; i < xo256_pkg::NWORDS; i++) gen_state[i] <= adv[i];
        end
        xo256_pkg::CMD_JSTEP: begin
          for (int i = 0; i < xo256_pkg::NWORDS; i++) gen_state[i] <= adv[i];
        end
        xo256_pkg::CMD_JEND: begin
          for (int i = 0; i < xo256_pkg::NWORDS; i++) gen_state[i] <= acc[i];
        end
        default: ;
      endcase
      if (cmd.cmd == xo256_pkg::CMD_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.cmd)
      xo256_pkg::CMD_LOAD: begin
        z         <= seed_value + xo256_pkg::GOLDEN_GAMMA;
        res_value <= '0;
        res_flag  <= 1'b0;
        for (int i = 0; i < xo256_pkg::NWORDS; i++) acc[i] <= '0;
      end
      xo256_pkg::CMD_MIX: begin
        mx <= cmd.mul_b ? (prod ^ (prod >> 27)) : (z ^ (z >> 30));
      end
      xo256_pkg::CMD_MUL: begin
        if (cmd.phase == '0) begin
          prod <= mul_p;
        end else begin
          prod[W-1:H] <= prod[W-1:H] + mul_p[H-1:0];
        end
      end
      xo256_pkg::CMD_STORE: z <= prod;
      xo256_pkg::CMD_SUM:   sum <= gen_state[0] + gen_state[3];
      xo256_pkg::CMD_STEP: begin
        res_value <= {sum[W-24:0], sum[W-1:W-23]} + gen_state[0];
        res_flag  <= 1'b1;
      end
      xo256_pkg::CMD_JSTEP: begin
        if (cmd.acc_en) begin
          for (int i = 0; i < xo256_pkg::NWORDS; i++) acc[i] <= acc[i] ^ gen_state[i];
        end
      end
      xo256_pkg::CMD_EMIT: begin
        random_value <= res_value;
        value_valid  <= res_flag;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/xoshiro256pp_generator.sv */
// xoshiro256++ generator, top level: controller plus datapath.
// Depends on xo256_pkg, xo256_ctrl and xo256_dp.
//
// Input channel (in_valid/in_ready): operation 0 seeds from seed_value,
// 1 returns the next output, 2 jumps 2^128 steps, 3 jumps 2^192 steps.
// Output channel (out_valid/out_ready): one item per input item;
// random_value with value_valid set for next, zero and clear otherwise.
// One item is worked at a time; in_ready is high only while idle.
// Next forms the sum, then steps the state. Seed uses one 32x32 multiplier
// shared over three passes per 64-bit product, eight products; jump and
// long jump take one state step per polynomial bit. The next item can be
// accepted once the result is loaded into the output register.
// A result waiting in the output register does not stop the next item
// from being accepted and worked; only its own result waits for the slot.
// Reset clears the state to zero; an unseeded generator returns zeros.
// Reset also empties the output register.
module xoshiro256pp_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [63:0] seed_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] random_value,
  output logic        value_valid
);

  xo256_pkg::ctrl_cmd_t  cmd;
  xo256_pkg::dp_status_t status;

  xo256_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .status    (status),
    .cmd       (cmd)
  );

  xo256_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .seed_value   (seed_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .random_value (random_value),
    .value_valid  (value_valid)
  );

`ifndef SYNTH
  // one item at a time: no accept in the cycle right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

  // non-next results carry a zero value
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !value_valid |-> random_value == '0)
    else $error("nonzero value without value_valid");

  // reset leaves the block idle with an empty output
  a_reset_idle: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // no result appears in the cycle after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result without work");
`endif

endmodule
